FILE: sv/multichannel_olympic_average_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trimmed-mean filter core
// Shared wrappers around concurrent assertions, clocked on
// clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_OLYMPIC_AVERAGE_CORE_ASSERT_SVH
`define MULTICHANNEL_OLYMPIC_AVERAGE_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define MOAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define MOAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/moac_pkg.sv
// ----------------------------------------------------------------------------
// moac_pkg
// Types and constants of the multichannel trimmed-mean filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package moac_pkg;

  // Default sizing
  localparam int CHANNELS_DEF  = 3;
  localparam int WINDOW_DEF    = 10;
  localparam int AVG_SHIFT_DEF = 3;

  // Fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 13;
  localparam int CH_OUT_W = 3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;
  localparam logic [MV_W-1:0]     FS_RESET   = 13'd3300;

  // Millivolt scaling: x / 4095 as (x * RECIP_4095) >> RECIP_SHIFT, plus one fixup
  localparam int                  FULL_CODE   = 4095;
  localparam int                  PROD_W      = SAMPLE_W + MV_W;   // avg * full scale
  localparam int                  RECIP_SHIFT = 36;
  localparam int                  QUO_W       = 2 * PROD_W - RECIP_SHIFT;
  localparam logic [PROD_W-1:0]   RECIP_4095  = 25'd16781313;     // floor(2^36 / 4095)

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_TRIM,
    ST_MUL,
    ST_RECIP,
    ST_FIX,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: sv/multichannel_olympic_average_core.sv
// ----------------------------------------------------------------------------
// multichannel_olympic_average_core
// Round-robin trimmed-mean (drop min and max) filter with millivolt scaling.
// ----------------------------------------------------------------------------
// Each accepted raw_sample belongs to the channel whose turn it is (channel 0
// first, then round-robin). The sample goes into that channel's ring of
// WINDOW entries, one slot past the previous write. The ring is then walked
// through a history memory with one write and one registered read port,
// one entry per cycle, by one shared adder and min/max compare; the trimmed
// sum is shifted right by AVG_SHIFT (saturating at 4095) and scaled to
// millivolts as avg * full_scale_mv / 4095, truncated. One item occupies the
// core through the accept cycle, a walk of the ring (one read per entry, then
// the read latency and the final check), then trim, multiply, reciprocal,
// fixup and hand-off; in_ready_o is low meanwhile. A finished result sits in
// an output register, so the next item is taken while it waits. After reset
// a clearing pass zeroes all CHANNELS * WINDOW history entries; no item is
// taken during it, configuration writes are. The user must write
// full_scale_mv only while idle; the core itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_olympic_average_core_assert.svh"

module multichannel_olympic_average_core #(
  parameter int CHANNELS  = moac_pkg::CHANNELS_DEF,
  parameter int WINDOW    = moac_pkg::WINDOW_DEF,
  parameter int AVG_SHIFT = moac_pkg::AVG_SHIFT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [moac_pkg::MV_W-1:0]     full_scale_mv_i,
  // Sample input
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [moac_pkg::SAMPLE_W-1:0] raw_sample_i,
  // Result output
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [moac_pkg::CH_OUT_W-1:0] channel_o,
  output      logic [moac_pkg::SAMPLE_W-1:0] average_o,
  output      logic [moac_pkg::MV_W-1:0]     millivolts_o
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = moac_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int SW     = moac_pkg::SAMPLE_W;
  localparam int PW     = moac_pkg::PROD_W;
  localparam int QW     = moac_pkg::QUO_W;

  // --------------------------------------------------------------------------
  // State and datapath registers
  // --------------------------------------------------------------------------
  moac_pkg::state_e state_q, state_d;

  logic [ADDR_W-1:0]         clr_q, clr_d;
  logic [CH_W-1:0]           turn_q, turn_d;
  logic [ADDR_W-1:0]         base_q, base_d;
  logic [SLOT_W-1:0]         wslot_q [CHANNELS];
  logic                      wslot_we;
  logic [SLOT_W-1:0]         slot_nxt;
  logic [SLOT_W:0]           slot_inc;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [SW-1:0]             lo_q, lo_d;
  logic [SW-1:0]             hi_q, hi_d;
  logic [SW-1:0]             avg_q, avg_d;
  logic [PW-1:0]             prod_q, prod_d;
  logic [2*PW-1:0]           rec_q, rec_d;
  logic [moac_pkg::MV_W-1:0] mv_q, mv_d;
  logic [moac_pkg::MV_W-1:0] fs_q;

  logic                          out_valid_q, out_valid_d;
  logic [moac_pkg::CH_OUT_W-1:0] out_ch_q, out_ch_d;
  logic [SW-1:0]                 out_avg_q, out_avg_d;
  logic [moac_pkg::MV_W-1:0]     out_mv_q, out_mv_d;

  // History memory ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SW-1:0]     wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [SW-1:0]     rd_data_q;
  logic [SW-1:0]     hist_mem [DEPTH];

  // Datapath helpers
  logic [SUM_W-1:0] trimmed;
  logic [SUM_W-1:0] shifted;
  logic [QW-1:0]    quo;
  logic [PW:0]      quo_x;
  logic [PW:0]      rem;

  // --------------------------------------------------------------------------
  // Next write slot of the current channel
  // --------------------------------------------------------------------------
  assign slot_inc = {1'b0, wslot_q[turn_q]} + (SLOT_W+1)'(1);
  assign slot_nxt = (slot_inc >= (SLOT_W+1)'(WINDOW)) ? '0 : slot_inc[SLOT_W-1:0];

  // --------------------------------------------------------------------------
  // Trim, shift and saturate
  // --------------------------------------------------------------------------
  assign trimmed = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
  assign shifted = trimmed >> AVG_SHIFT;

  // --------------------------------------------------------------------------
  // Reciprocal fixup: quotient may be one short
  // --------------------------------------------------------------------------
  assign quo   = rec_q[moac_pkg::RECIP_SHIFT +: QW];
  assign quo_x = (PW+1)'({quo, 12'b0}) - (PW+1)'(quo);
  assign rem   = (PW+1)'(prod_q) - quo_x;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    turn_d      = turn_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    sum_d       = sum_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    avg_d       = avg_q;
    prod_d      = prod_q;
    rec_d       = rec_q;
    mv_d        = mv_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_ch_d    = out_ch_q;
    out_avg_d   = out_avg_q;
    out_mv_d    = out_mv_q;
    in_ready_o  = 1'b0;
    wslot_we    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = base_q + ADDR_W'(slot_nxt);
    wr_data     = raw_sample_i;
    rd_addr     = base_q + ADDR_W'(cnt_q);

    case (state_q)
      // Zero the history after reset
      moac_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = moac_pkg::ST_IDLE;
        end
      end
      // Take a sample, store it in the next slot
      moac_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          wr_en    = 1'b1;
          wslot_we = 1'b1;
          cnt_d    = '0;
          sum_d    = '0;
          lo_d     = moac_pkg::SAMPLE_MAX;
          hi_d     = '0;
          state_d  = moac_pkg::ST_SUM;
        end
      end
      // Walk the ring: issue one read, accumulate the previous one
      moac_pkg::ST_SUM: begin
        if (cnt_q != CNT_W'(WINDOW)) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          sum_d = sum_q + SUM_W'(rd_data_q);
          if (rd_data_q < lo_q) begin
            lo_d = rd_data_q;
          end
          if (rd_data_q > hi_q) begin
            hi_d = rd_data_q;
          end
        end else if (cnt_q == CNT_W'(WINDOW)) begin
          state_d = moac_pkg::ST_TRIM;
        end
      end
      moac_pkg::ST_TRIM: begin
        avg_d   = (shifted > SUM_W'(moac_pkg::SAMPLE_MAX)) ? moac_pkg::SAMPLE_MAX
                                                           : shifted[SW-1:0];
        state_d = moac_pkg::ST_MUL;
      end
      moac_pkg::ST_MUL: begin
        prod_d  = PW'(avg_q) * PW'(fs_q);
        state_d = moac_pkg::ST_RECIP;
      end
      moac_pkg::ST_RECIP: begin
        rec_d   = (2*PW)'(prod_q) * (2*PW)'(moac_pkg::RECIP_4095);
        state_d = moac_pkg::ST_FIX;
      end
      moac_pkg::ST_FIX: begin
        mv_d    = (rem >= (PW+1)'(moac_pkg::FULL_CODE)) ? moac_pkg::MV_W'(quo + QW'(1))
                                                        : moac_pkg::MV_W'(quo);
        state_d = moac_pkg::ST_DONE;
      end
      // Hand the item to the output register, advance the turn
      moac_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ch_d    = moac_pkg::CH_OUT_W'(turn_q);
          out_avg_d   = avg_q;
          out_mv_d    = mv_q;
          state_d     = moac_pkg::ST_IDLE;
          if (turn_q >= CH_W'(CHANNELS - 1)) begin
            turn_d = '0;
            base_d = '0;
          end else begin
            turn_d = turn_q + CH_W'(1);
            base_d = base_q + ADDR_W'(WINDOW);
          end
        end
      end
      default: begin
        state_d = moac_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= moac_pkg::ST_CLEAR;
      clr_q       <= '0;
      turn_q      <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      fs_q        <= moac_pkg::FS_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      turn_q      <= turn_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        fs_q <= full_scale_mv_i;
      end
    end
  end

  // Per-channel write slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wslot_q[c] <= '0;
      end
    end else if (wslot_we) begin
      wslot_q[turn_q] <= slot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    avg_q     <= avg_d;
    prod_q    <= prod_d;
    rec_q     <= rec_d;
    mv_q      <= mv_d;
    out_ch_q  <= out_ch_d;
    out_avg_q <= out_avg_d;
    out_mv_q  <= out_mv_d;
  end

  // --------------------------------------------------------------------------
  // History memory: one write, one registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  // Ports
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign channel_o    = out_ch_q;
  assign average_o    = out_avg_q;
  assign millivolts_o = out_mv_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MOAC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                    "ready right after accept")
  `MOAC_ASSERT_NEXT(a_done_holds,
                    (state_q == moac_pkg::ST_DONE) && out_valid_o && !out_ready_i,
                    state_q == moac_pkg::ST_DONE, "result overwrote a pending output")
  `MOAC_ASSERT_SAME(a_mv_bounded, out_valid_o, millivolts_o <= fs_q,
                    "millivolts above full scale")
  `MOAC_ASSERT_SAME(a_turn_range, 1'b1, turn_q <= CH_W'(CHANNELS - 1),
                    "turn out of range")
  `MOAC_ASSERT_SAME(a_fix_once, state_q == moac_pkg::ST_FIX,
                    rem < (PW+1)'(2 * moac_pkg::FULL_CODE),
                    "reciprocal off by more than one")

endmodule

`default_nettype wire
